// ===== design/tcc_pkg.sv =====
`default_nettype none
package tcc_pkg;

  localparam logic [1:0] ReqClear = 2'd0;
  localparam logic [1:0] ReqPut   = 2'd1;
  localparam logic [1:0] ReqRead  = 2'd2;

  localparam logic [7:0] BlankChar   = 8'h20;
  localparam logic [7:0] NewlineChar = 8'h0a;
  localparam logic [7:0] ReturnChar  = 8'h0d;
  localparam logic [7:0] AttrReset   = 8'h07;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcc_req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
  } tcc_rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StClear,
    StScrRd,
    StScrWr,
    StBlank,
    StRdWait,
    StDone
  } tcc_state_e;

endpackage
`default_nettype wire

// ===== design/tcc_ram.sv =====
`default_nettype none
module tcc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== design/text_console_cursor_scroll.sv =====
// Text console with a COLS x ROWS cell screen and a cursor. Issue a request
// with start while busy is low; the single result word appears on rsp_o for
// one cycle with done_o high and must be taken then, the block cannot be
// stalled. All cell traffic goes through one single-port-write screen RAM
// with registered read; clear and scroll passes step one address counter.
// A scrolling put moves each row up and blanks the last row, a clear writes
// every cell, a read waits on the registered RAM read, and an unused kind
// goes straight to done. Screen contents are undefined after reset until
// the first clear; there is no clearing pass. The attribute register is
// written with attr_we_i and must only change while busy is low.
`default_nettype none
module text_console_cursor_scroll import tcc_pkg::*; #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  input  wire tcc_req_t req_i,
  output logic          busy,
  output logic          done_o,
  output tcc_rsp_t      rsp_o,
  input  wire logic     attr_we_i,
  input  wire logic [7:0] attr_wdata_i
);

  localparam int unsigned CELLS = COLS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned RW    = $clog2(ROWS);

  localparam logic [AW-1:0] LastCell   = AW'(CELLS - 1);
  localparam logic [AW-1:0] LastMove   = AW'(CELLS - COLS - 1);
  localparam logic [AW-1:0] LastRowIdx = AW'(CELLS - COLS);
  localparam logic [AW-1:0] ColStep    = AW'(COLS);
  localparam logic [CW:0]   ColEnd     = (CW + 1)'(COLS);
  localparam logic [RW-1:0] LastRow    = RW'(ROWS - 1);

  tcc_state_e state_q, state_d;
  logic [7:0]    attr_q;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [15:0]   data_q, data_d;

  logic          accept;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata, mem_rdata;
  logic [AW-1:0] cur_addr;
  logic [CW:0]   col_inc;
  logic          cell_ok;
  logic          is_nl, is_cr;
  logic          row_adv;
  logic [15:0]   blank;

  assign accept   = start && !busy;
  assign busy     = (state_q != StIdle);
  assign cur_addr = AW'(row_q * COLS) + AW'(col_q);
  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign cell_ok  = (32'(req_i.cell_index) < CELLS);
  assign is_nl    = (req_i.char_code == NewlineChar);
  assign is_cr    = (req_i.char_code == ReturnChar);
  assign row_adv  = is_nl || (!is_cr && (col_inc == ColEnd));
  assign blank    = {attr_q, BlankChar};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (req_i.req_type)
            ReqClear: state_d = StClear;
            ReqPut:   state_d = (row_adv && row_q == LastRow) ? StScrRd : StDone;
            ReqRead:  state_d = cell_ok ? StRdWait : StDone;
            default:  state_d = StDone;
          endcase
        end
      end
      StClear:  if (ptr_q == LastCell) state_d = StDone;
      StScrRd:  state_d = StScrWr;
      StScrWr:  state_d = (ptr_q == LastMove) ? StBlank : StScrRd;
      StBlank:  if (ptr_q == LastCell) state_d = StDone;
      StRdWait: state_d = StDone;
      StDone:   state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // datapath and memory control
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    ptr_d     = ptr_q;
    data_d    = data_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = blank;
    mem_raddr = ptr_q + ColStep;
    unique case (state_q)
      StIdle: begin
        ptr_d = '0;
        if (accept) begin
          data_d = '0;
          unique case (req_i.req_type)
            ReqClear: begin
              col_d = '0;
              row_d = '0;
            end
            ReqPut: begin
              if (!is_nl && !is_cr) begin
                mem_we    = 1'b1;
                mem_waddr = cur_addr;
                mem_wdata = {attr_q, req_i.char_code};
              end
              col_d = (is_nl || is_cr || row_adv) ? '0 : col_inc[CW-1:0];
              if (row_adv && row_q != LastRow) begin
                row_d = row_q + 1'b1;
              end
            end
            ReqRead: mem_raddr = AW'(req_i.cell_index);
            default: ;
          endcase
        end
      end
      StClear, StBlank: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + 1'b1;
      end
      StScrRd: ;
      StScrWr: begin
        // move the row below up by one row
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        ptr_d     = (ptr_q == LastMove) ? LastRowIdx : ptr_q + 1'b1;
      end
      StRdWait: data_d = mem_rdata;
      StDone:   ;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      attr_q  <= AttrReset;
      col_q   <= '0;
      row_q   <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      ptr_q   <= ptr_d;
      if (attr_we_i) begin
        attr_q <= attr_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  tcc_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign done_o           = (state_q == StDone);
  assign rsp_o.read_data  = data_q;
  assign rsp_o.cursor_col = 7'(col_q);
  assign rsp_o.cursor_row = 5'(row_q);

endmodule
`default_nettype wire

// ===== dv/tb_text_console_cursor_scroll.sv =====
`default_nettype none
module tb_text_console_cursor_scroll;
  import tcc_pkg::*;

  localparam int Cols      = 80;
  localparam int Rows      = 25;
  localparam int CellCount = Cols * Rows;
  localparam int CycleLimit = 4_000_000;
  localparam logic [1:0] ReqUnused = 2'd3;

  // screen model, cursor and attribute; holds the words still owed by the block
  class console_scoreboard;
    logic [15:0] cells[CellCount];
    bit          known[CellCount];
    int          col;
    int          row;
    logic [7:0]  attr;
    tcc_rsp_t    pending[$];
    int          errors;
    int          checked;
    int          reads;
    int          scrolls;
    int          wraps;
    int          clears;

    function new();
      attr = AttrReset;
      col = 0;
      row = 0;
      foreach (known[i]) known[i] = 1'b0;
    endfunction

    function void note_request(tcc_req_t w);
      tcc_rsp_t exp_word;
      exp_word.read_data = '0;
      case (w.req_type)
        ReqClear: begin
          for (int i = 0; i < CellCount; i++) begin
            cells[i] = {attr, BlankChar};
            known[i] = 1'b1;
          end
          col = 0;
          row = 0;
          clears++;
        end
        ReqPut: begin
          if (w.char_code == NewlineChar) begin
            col = 0;
            row++;
          end else if (w.char_code == ReturnChar) begin
            col = 0;
          end else begin
            cells[row * Cols + col] = {attr, w.char_code};
            known[row * Cols + col] = 1'b1;
            col++;
          end
          if (col >= Cols) begin
            col = 0;
            row++;
            wraps++;
          end
          if (row >= Rows) begin
            for (int i = 0; i < CellCount - Cols; i++) begin
              cells[i] = cells[i + Cols];
              known[i] = known[i + Cols];
            end
            for (int i = CellCount - Cols; i < CellCount; i++) begin
              cells[i] = {attr, BlankChar};
              known[i] = 1'b1;
            end
            row = Rows - 1;
            scrolls++;
          end
        end
        ReqRead: begin
          reads++;
          if (w.cell_index < CellCount) exp_word.read_data = cells[w.cell_index];
        end
        default: ;
      endcase
      exp_word.cursor_col = col[6:0];
      exp_word.cursor_row = row[4:0];
      pending.push_back(exp_word);
    endfunction

    function void check_result(tcc_rsp_t got);
      tcc_rsp_t exp_word;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      exp_word = pending.pop_front();
      checked++;
      if (got.read_data !== exp_word.read_data) begin
        $error("read_data: expected %h, got %h", exp_word.read_data, got.read_data);
        errors++;
      end
      if (got.cursor_col !== exp_word.cursor_col) begin
        $error("cursor_col: expected %0d, got %0d", exp_word.cursor_col, got.cursor_col);
        errors++;
      end
      if (got.cursor_row !== exp_word.cursor_row) begin
        $error("cursor_row: expected %0d, got %0d", exp_word.cursor_row, got.cursor_row);
        errors++;
      end
    endfunction

    // a cell that holds defined contents, or an out-of-range index if none does
    function logic [10:0] readable_cell();
      int last;
      int first;
      last = row * Cols + col - 1;
      if (last >= 0 && known[last] && $urandom_range(2) == 0) return last[10:0];
      first = $urandom_range(CellCount - 1);
      for (int k = 0; k < CellCount; k++)
        if (known[(first + k) % CellCount]) return 11'((first + k) % CellCount);
      return 11'($urandom_range(2047, CellCount));
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  tcc_req_t req_i;
  logic     busy;
  logic     done_o;
  tcc_rsp_t rsp_o;
  logic     attr_we_i;
  logic [7:0] attr_wdata_i;

  console_scoreboard sb;
  int idle_pct;
  int items_sent;
  int cycle_count;

  text_console_cursor_scroll uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .req_i        (req_i),
    .busy         (busy),
    .done_o       (done_o),
    .rsp_o        (rsp_o),
    .attr_we_i    (attr_we_i),
    .attr_wdata_i (attr_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(rsp_o);
  end

  function automatic tcc_req_t make_word(logic [1:0] kind, logic [7:0] ch,
                                         logic [10:0] idx);
    tcc_req_t w;
    w.req_type = kind;
    w.char_code = ch;
    w.cell_index = idx;
    return w;
  endfunction

  task automatic send_word(tcc_req_t w);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 3) : 0;
    @(negedge clk_i);
    repeat (gap) begin
      start <= 1'b0;
      req_i <= tcc_req_t'($urandom);
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy);
    sb.note_request(w);
    items_sent++;
  endtask

  task automatic put_char(logic [7:0] ch);
    send_word(make_word(ReqPut, ch, 11'($urandom)));
  endtask

  task automatic read_cell(logic [10:0] idx);
    send_word(make_word(ReqRead, 8'($urandom), idx));
  endtask

  // only while nothing is in flight
  task automatic write_attribute(logic [7:0] value);
    @(negedge clk_i);
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0 || busy);
    @(negedge clk_i);
    attr_we_i <= 1'b1;
    attr_wdata_i <= value;
    @(posedge clk_i);
    sb.attr = value;
    @(negedge clk_i);
    attr_we_i <= 1'b0;
    attr_wdata_i <= 8'($urandom);
  endtask

  task automatic random_phase(int count, bit long_line);
    int goal;
    int pick;
    int run;
    goal = items_sent + count;
    if (long_line) begin
      // enough plain bytes to wrap past column 79
      run = $urandom_range(80, 100);
      repeat (run) put_char(8'($urandom_range(32, 126)));
    end
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        run = $urandom_range(1, 12);
        repeat (run) put_char(8'($urandom_range(255)));
      end else if (pick < 62) begin
        run = $urandom_range(1, 6);
        repeat (run) put_char(NewlineChar);
      end else if (pick < 82) begin
        read_cell(sb.readable_cell());
      end else if (pick < 87) begin
        put_char(ReturnChar);
      end else if (pick < 92) begin
        send_word(make_word(ReqUnused, 8'($urandom), 11'($urandom)));
      end else if (pick < 95) begin
        send_word(make_word(ReqClear, 8'($urandom), 11'($urandom)));
      end else begin
        read_cell(11'($urandom_range(2047, CellCount)));
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    attr_we_i = 1'b0;
    attr_wdata_i = '0;
    idle_pct = 20;
    items_sent = 0;
    cycle_count = 0;
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset attribute, byte extremes, every request kind
    put_char(8'h41);
    read_cell(11'd0);
    read_cell(11'd2047);
    read_cell(11'(CellCount));
    send_word(make_word(ReqUnused, 8'hff, 11'h7ff));
    send_word(make_word(ReqClear, 8'hff, 11'h7ff));
    read_cell(11'd0);
    read_cell(11'(CellCount - 1));
    put_char(8'h00);
    put_char(8'hff);
    put_char(BlankChar);
    read_cell(11'd0);
    read_cell(11'd1);
    read_cell(11'd2);
    put_char(ReturnChar);
    put_char(8'h7e);
    read_cell(11'd0);
    put_char(NewlineChar);
    put_char(8'h80);
    read_cell(11'(Cols));
    send_word(make_word(ReqUnused, 8'h00, 11'h000));

    write_attribute(8'hff);
    random_phase(25, 1'b0);
    write_attribute(8'h00);
    idle_pct = 0;
    random_phase(90, 1'b1);
    write_attribute(8'($urandom));
    idle_pct = 20;
    random_phase(15, 1'b0);

    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("sent %0d words, checked %0d results: %0d reads, %0d clears",
             items_sent, sb.checked, sb.reads, sb.clears);
    $display("cursor wrapped %0d times, screen scrolled %0d times",
             sb.wraps, sb.scrolls);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/tcc_pkg.sv
design/tcc_ram.sv
design/text_console_cursor_scroll.sv
dv/tb_text_console_cursor_scroll.sv
